FILE: rtl/core/dwpid_pkg.sv
// shared types and constants of the dual wheel incremental pid speed unit
// no dependencies; imported by the config bank, the multiplier, the top level and the testbench
package dwpid_pkg;

    // field and datapath widths
    localparam int COUNT_W    = 16;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 88;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 27;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SPEED_W    = 24;
    localparam int CTRL_W     = 16;
    localparam int ACC_W      = 43;
    localparam int DELTA_W    = 18;

    // control clamp, +/-100 percent in q.8
    localparam logic signed [CTRL_W-1:0] CTRL_LIM = 16'sd25600;

    // ceil(2^32 / 100), exact floor division by 100 for operands below 2^23
    localparam logic [25:0] DIV100_RECIP = 26'd42949673;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_NOW   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_LAST  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_OLDER = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THR    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_TOP     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FULL   = 4'd7;

    // configuration bank contents
    typedef struct packed {
        logic signed [15:0] coeff_now;
        logic signed [15:0] coeff_last;
        logic signed [15:0] coeff_older;
        logic [19:0]        speed_gain;
        logic [15:0]        wrap_threshold;
        logic [15:0]        encoder_top;
        logic [15:0]        pwm_top;
        logic [15:0]        duty_full_scale;
    } t_cfg;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_op;

    // sequencer steps, one wheel pass from S_WRAP to S_OUT
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_MSPD,
        S_SPD,
        S_M0,
        S_M1,
        S_M2,
        S_ACC,
        S_CTRL,
        S_MDUTY,
        S_MDIV,
        S_OUT,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/dwpid_cfg.sv
// configuration register bank with reset defaults
// depends on dwpid_pkg for the register indexes and the t_cfg struct
module dwpid_cfg import dwpid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_now       <= 16'sd5407;
            r_cfg.coeff_last      <= -16'sd1843;
            r_cfg.coeff_older     <= 16'sd0;
            r_cfg.speed_gain      <= 20'd49276;
            r_cfg.wrap_threshold  <= 16'd200;
            r_cfg.encoder_top     <= 16'd65535;
            r_cfg.pwm_top         <= 16'd999;
            r_cfg.duty_full_scale <= 16'd999;
        end else if (i_we) begin
            unique case (i_index)
                REG_COEFF_NOW:   r_cfg.coeff_now       <= i_data[15:0];
                REG_COEFF_LAST:  r_cfg.coeff_last      <= i_data[15:0];
                REG_COEFF_OLDER: r_cfg.coeff_older     <= i_data[15:0];
                REG_SPEED_GAIN:  r_cfg.speed_gain      <= i_data;
                REG_WRAP_THR:    r_cfg.wrap_threshold  <= i_data[15:0];
                REG_ENC_TOP:     r_cfg.encoder_top     <= i_data[15:0];
                REG_PWM_TOP:     r_cfg.pwm_top         <= i_data[15:0];
                REG_DUTY_FULL:   r_cfg.duty_full_scale <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/dwpid_mul.sv
// shared signed multiplier with a registered product
// depends on dwpid_pkg for operand widths and the t_mul_op struct
module dwpid_mul import dwpid_pkg::*; (
    input  logic                      i_clk,
    input  t_mul_op                   i_op,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    // one product per cycle, ready the cycle after issue
    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/dual_wheel_incremental_pid_speed_unit.sv
// dual wheel incremental pid speed unit, top level with sequencer and datapath
// an input transaction runs the left and then the right wheel pass, 11 steps per wheel
// one item in flight at a time: input is taken only in S_IDLE, and one multiplier serves every step
// the next input is taken while a finished result still waits on the output
// reset (synchronous, active low) restores register defaults and clears history
// depends on dwpid_pkg, dwpid_cfg and dwpid_mul
module dual_wheel_incremental_pid_speed_unit import dwpid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // count_left, count_right, target_left, target_right
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // compare_left, reverse_left, compare_right, reverse_right,
    // speed_left, speed_right, zero pad
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    t_cfg                      cfg;
    t_mul_op                   mul_op;
    logic signed [MUL_P_W-1:0] mul_prod;

    t_state r_state, n_state;
    logic   r_wheel;

    // latched item
    logic [COUNT_W-1:0] r_cnt_in [2];
    logic signed [7:0]  r_tgt    [2];

    // per wheel history
    logic [COUNT_W-1:0]        r_prev_cnt [2];
    logic signed [CTRL_W-1:0]  r_prev_u   [2];
    logic signed [SPEED_W-1:0] r_e1       [2];
    logic signed [SPEED_W-1:0] r_e2       [2];

    // working registers
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [SPEED_W-1:0] r_err;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [CTRL_W-1:0]  r_u;

    // per wheel results and output register
    logic [16:0]               r_cmp [2];
    logic                      r_rev [2];
    logic signed [SPEED_W-1:0] r_spd [2];
    logic                      r_m_valid;
    logic [OUT_W-1:0]          r_m_data;

    logic in_fire, out_free;

    dwpid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dwpid_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (mul_prod)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;

    // count delta with wrap correction
    logic [COUNT_W-1:0]        cnow, cold;
    logic signed [COUNT_W:0]   delta_raw;
    logic [COUNT_W:0]          delta_mag;
    logic [16:0]               enc_span;
    logic signed [DELTA_W-1:0] delta_ext, delta_fix;

    always_comb begin
        cnow      = r_cnt_in[r_wheel];
        cold      = r_prev_cnt[r_wheel];
        delta_raw = $signed({1'b0, cnow}) - $signed({1'b0, cold});
        delta_mag = delta_raw[COUNT_W] ? (COUNT_W+1)'(-delta_raw) : (COUNT_W+1)'(delta_raw);
        enc_span  = {1'b0, cfg.encoder_top} + 17'd1;
        delta_ext = {delta_raw[COUNT_W], delta_raw};
        delta_fix = delta_ext;
        if (delta_mag > {1'b0, cfg.wrap_threshold}) begin
            if (delta_raw[COUNT_W]) begin
                delta_fix = delta_ext + $signed({1'b0, enc_span});
            end else begin
                delta_fix = delta_ext - $signed({1'b0, enc_span});
            end
        end
    end

    // speed rounding and saturation, error against set point
    logic signed [MUL_P_W-1:0] spd_shift;
    logic signed [SPEED_W-1:0] spd_sat;
    logic signed [7:0]         tgt;
    logic signed [17:0]        sp_pos, sp;
    logic signed [SPEED_W:0]   err_diff;
    logic signed [SPEED_W-1:0] err_sat;

    always_comb begin
        spd_shift = (mul_prod + 51'sd128) >>> 8;
        if ((&spd_shift[MUL_P_W-1:SPEED_W-1]) || !(|spd_shift[MUL_P_W-1:SPEED_W-1])) begin
            spd_sat = spd_shift[SPEED_W-1:0];
        end else begin
            spd_sat = spd_shift[MUL_P_W-1] ? 24'sh800000 : 24'sh7FFFFF;
        end
        tgt      = r_tgt[r_wheel];
        sp_pos   = {{2{tgt[7]}}, tgt, 8'b0};
        sp       = r_wheel ? -sp_pos : sp_pos;
        err_diff = {{7{sp[17]}}, sp} - {spd_sat[SPEED_W-1], spd_sat};
        if (err_diff[SPEED_W] == err_diff[SPEED_W-1]) begin
            err_sat = err_diff[SPEED_W-1:0];
        end else begin
            err_sat = err_diff[SPEED_W] ? 24'sh800000 : 24'sh7FFFFF;
        end
    end

    // control update and clamp
    logic signed [ACC_W-1:0]  acc_round;
    logic signed [31:0]       u_sum;
    logic signed [CTRL_W-1:0] u_clamp;

    always_comb begin
        acc_round = r_acc + 43'sd2048;
        u_sum     = 32'($signed(acc_round[ACC_W-1:12])) + 32'(r_prev_u[r_wheel]);
        if (r_tgt[r_wheel] == 8'sd0) begin
            u_clamp = '0;
        end else if (u_sum > 32'(CTRL_LIM)) begin
            u_clamp = CTRL_LIM;
        end else if (u_sum < -32'(CTRL_LIM)) begin
            u_clamp = -CTRL_LIM;
        end else begin
            u_clamp = u_sum[CTRL_W-1:0];
        end
    end

    // duty to compare value and direction
    logic [CTRL_W-1:0]  u_abs;
    logic [15:0]        duty;
    logic [16:0]        pwm_span;
    logic signed [17:0] cmp_rev;
    logic               rev;
    logic [16:0]        cmp;

    always_comb begin
        u_abs    = r_u[CTRL_W-1] ? CTRL_W'(-r_u) : CTRL_W'(r_u);
        duty     = mul_prod[47:32];
        pwm_span = {1'b0, cfg.pwm_top} + 17'd1;
        cmp_rev  = $signed({1'b0, pwm_span}) - $signed({2'b0, duty});
        rev      = r_wheel ? (r_u > 16'sd0) : r_u[CTRL_W-1];
        if (!rev) begin
            cmp = {1'b0, duty};
        end else if (cmp_rev[17]) begin
            cmp = '0;
        end else begin
            cmp = cmp_rev[16:0];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiplier operand selection
    always_comb begin
        n_state  = r_state;
        mul_op.a = '0;
        mul_op.b = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_WRAP;
            end
            S_WRAP:  n_state = S_MSPD;
            S_MSPD: begin
                mul_op.a = MUL_A_W'(r_delta);
                mul_op.b = $signed({7'b0, cfg.speed_gain});
                n_state  = S_SPD;
            end
            S_SPD:   n_state = S_M0;
            S_M0: begin
                mul_op.a = r_err;
                mul_op.b = MUL_B_W'(cfg.coeff_now);
                n_state  = S_M1;
            end
            S_M1: begin
                mul_op.a = r_e1[r_wheel];
                mul_op.b = MUL_B_W'(cfg.coeff_last);
                n_state  = S_M2;
            end
            S_M2: begin
                mul_op.a = r_e2[r_wheel];
                mul_op.b = MUL_B_W'(cfg.coeff_older);
                n_state  = S_ACC;
            end
            S_ACC:   n_state = S_CTRL;
            S_CTRL:  n_state = S_MDUTY;
            S_MDUTY: begin
                mul_op.a = $signed({8'b0, u_abs});
                mul_op.b = $signed({11'b0, cfg.duty_full_scale});
                n_state  = S_MDIV;
            end
            S_MDIV: begin
                mul_op.a = $signed({1'b0, mul_prod[30:8]});
                mul_op.b = $signed({1'b0, DIV100_RECIP});
                n_state  = S_OUT;
            end
            S_OUT:   n_state = r_wheel ? S_DONE : S_WRAP;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // wheel select, history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel   <= 1'b0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_prev_cnt[i] <= '0;
                r_prev_u[i]   <= '0;
                r_e1[i]       <= '0;
                r_e2[i]       <= '0;
            end
        end else begin
            // a new result replaces a consumed one in the same cycle
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_wheel <= 1'b0;
                end
                S_OUT: begin
                    r_prev_cnt[r_wheel] <= cnow;
                    r_prev_u[r_wheel]   <= r_u;
                    r_e2[r_wheel]       <= r_e1[r_wheel];
                    r_e1[r_wheel]       <= r_err;
                    r_wheel             <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers of the datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_cnt_in[0] <= i_s_axis_tdata[15:0];
                    r_cnt_in[1] <= i_s_axis_tdata[31:16];
                    r_tgt[0]    <= i_s_axis_tdata[39:32];
                    r_tgt[1]    <= i_s_axis_tdata[47:40];
                end
            end
            S_WRAP: r_delta <= delta_fix;
            S_SPD: begin
                r_speed <= spd_sat;
                r_err   <= err_sat;
            end
            S_M1:   r_acc <= mul_prod[ACC_W-1:0];
            S_M2:   r_acc <= r_acc + mul_prod[ACC_W-1:0];
            S_ACC:  r_acc <= r_acc + mul_prod[ACC_W-1:0];
            S_CTRL: r_u   <= u_clamp;
            S_OUT: begin
                r_cmp[r_wheel] <= cmp;
                r_rev[r_wheel] <= rev;
                r_spd[r_wheel] <= r_speed;
            end
            S_DONE: begin
                if (out_free) begin
                    r_m_data <= {4'b0, r_spd[1], r_spd[0], r_rev[1], r_cmp[1],
                                 r_rev[0], r_cmp[0]};
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // a result only appears right after the final step
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == S_DONE)
        else $error("result valid raised outside the final step");

    // the final step hands over once the output slot is free
    a_done_hands_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_m_valid && r_state == S_IDLE))
        else $error("final step did not load the output register");

    // left pass is followed by the right pass
    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_wheel) |=> (r_state == S_WRAP && r_wheel))
        else $error("right wheel pass did not follow the left pass");

    // stored control stays within the clamp
    a_ctrl_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_u[0] <= CTRL_LIM && r_prev_u[0] >= -CTRL_LIM &&
         r_prev_u[1] <= CTRL_LIM && r_prev_u[1] >= -CTRL_LIM))
        else $error("stored control outside the clamp range");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// testbench for the dual wheel incremental pid speed unit: directed ticks, then random
// register settings with encoder motion and noise, each result checked by an in-bench predictor
// depends on dwpid_pkg and dual_wheel_incremental_pid_speed_unit
module tb_top;
    import dwpid_pkg::*;

    // input transaction, count_left in the lowest bits
    typedef struct packed {
        logic signed [7:0] target_right;
        logic signed [7:0] target_left;
        logic [15:0]       count_right;
        logic [15:0]       count_left;
    } tick_t;

    // output transaction, compare_left in the lowest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [23:0] speed_right;
        logic signed [23:0] speed_left;
        logic               reverse_right;
        logic [16:0]        compare_right;
        logic               reverse_left;
        logic [16:0]        compare_left;
    } drive_t;

    typedef enum {CFG_DEFAULT, CFG_MILD, CFG_ANY, CFG_SHORT_ENCODER, CFG_EXTREME} cfg_style_t;

    localparam int     SETTLE_CYCLES = 30;
    localparam longint SPEED_HI      = 8388607;
    localparam longint SPEED_LO      = -8388608;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;

    // predictor copy of registers and per wheel history
    t_cfg               cfg_shadow;
    logic [15:0]        last_count [2];
    logic signed [15:0] last_ctrl [2];
    logic signed [23:0] err_one [2];
    logic signed [23:0] err_two [2];
    drive_t             drive_q [$];

    int fail_count = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int settings_used = 0;
    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;

    // encoder motion model for the random part
    int                pos_w [2] = '{0, 0};
    int                vel_w [2] = '{0, 0};
    int                run_w [2] = '{0, 0};
    logic signed [7:0] tgt_w [2] = '{8'sd0, 8'sd0};

    dual_wheel_incremental_pid_speed_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop
    initial begin
        #2000000;
        $display("FAIL dual_wheel_incremental_pid_speed_unit");
        $finish;
    end

    function automatic longint sat_val(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // reset state of registers and history
    function automatic void restore_predictor();
        cfg_shadow.coeff_now       = 16'sd5407;
        cfg_shadow.coeff_last      = -16'sd1843;
        cfg_shadow.coeff_older     = 16'sd0;
        cfg_shadow.speed_gain      = 20'd49276;
        cfg_shadow.wrap_threshold  = 16'd200;
        cfg_shadow.encoder_top     = 16'd65535;
        cfg_shadow.pwm_top         = 16'd999;
        cfg_shadow.duty_full_scale = 16'd999;
        for (int w = 0; w < 2; w++) begin
            last_count[w] = '0;
            last_ctrl[w]  = '0;
            err_one[w]    = '0;
            err_two[w]    = '0;
        end
    endfunction

    // one wheel: delta with wrap fix, speed, error, incremental pid, pwm compare
    function automatic void predict_wheel(input int w, input logic [15:0] cnt,
            input logic signed [7:0] tgt, input bit right, output logic [16:0] cmp,
            output logic rev, output logic signed [23:0] spd);
        longint cnow, cold, delta, mag, thr, span, gain, speed, t, setp, err;
        longint q0, q1, q2, e1, e2, acc, u, au, duty, c;
        bit     reversed;
        cnow  = cnt;
        cold  = last_count[w];
        thr   = cfg_shadow.wrap_threshold;
        span  = cfg_shadow.encoder_top;
        span  = span + 1;
        gain  = cfg_shadow.speed_gain;
        delta = cnow - cold;
        mag   = (delta < 0) ? -delta : delta;
        if (mag > thr)
            delta = delta + ((cold > cnow) ? span : -span);
        speed = sat_val((delta * gain + 128) >>> 8, SPEED_LO, SPEED_HI);
        t     = tgt;
        setp  = right ? -t * 256 : t * 256;
        err   = sat_val(setp - speed, SPEED_LO, SPEED_HI);

        // zero set point forces zero control, history still moves
        u = 0;
        if (t != 0) begin
            q0  = $signed(cfg_shadow.coeff_now);
            q1  = $signed(cfg_shadow.coeff_last);
            q2  = $signed(cfg_shadow.coeff_older);
            e1  = err_one[w];
            e2  = err_two[w];
            acc = q0 * err + q1 * e1 + q2 * e2;
            u   = ((acc + 2048) >>> 12) + longint'(last_ctrl[w]);
        end
        u = sat_val(u, -longint'(CTRL_LIM), longint'(CTRL_LIM));

        // duty and direction, reversed compare floors at zero
        au       = (u < 0) ? -u : u;
        duty     = (au * longint'(cfg_shadow.duty_full_scale)) / 25600;
        reversed = right ? (u > 0) : (u < 0);
        c        = duty;
        if (reversed) begin
            c = longint'(cfg_shadow.pwm_top) + 1 - duty;
            if (c < 0)
                c = 0;
        end
        cmp = c[16:0];
        rev = reversed;
        spd = speed[23:0];

        last_count[w] = cnt;
        last_ctrl[w]  = u[15:0];
        err_two[w]    = err_one[w];
        err_one[w]    = err[23:0];
    endfunction

    function automatic void predict_tick(input tick_t t);
        drive_t d;
        d = '0;
        predict_wheel(0, t.count_left, t.target_left, 1'b0,
                      d.compare_left, d.reverse_left, d.speed_left);
        predict_wheel(1, t.count_right, t.target_right, 1'b1,
                      d.compare_right, d.reverse_right, d.speed_right);
        drive_q.push_back(d);
    endfunction

    // idle length, mostly short with a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [7:0] rand_pct();
        int v;
        v = $urandom_range(0, 200);
        v = v - 100;
        return v[7:0];
    endfunction

    function automatic int pick_edge(input int lo, input int hi);
        return $urandom_range(1) ? hi : lo;
    endfunction

    // receiver backpressure
    initial begin : out_stall
        int   hold;
        logic level;
        hold  = 0;
        level = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!stalls_on) begin
                level = 1'b1;
                hold  = 0;
            end else if (hold == 0) begin
                level = ~level;
                hold  = level ? $urandom_range(1, 20) : pick_gap();
            end else begin
                hold--;
            end
            i_m_axis_tready <= level;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result checker, oldest expectation first
    drive_t res_got;
    drive_t res_want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            res_got = o_m_axis_tdata;
            results_seen++;
            if (drive_q.size() == 0) begin
                $error("result transaction with no pending expectation");
                fail_count++;
            end else begin
                res_want = drive_q.pop_front();
                check_field("compare_left", res_want.compare_left, res_got.compare_left);
                check_field("reverse_left", res_want.reverse_left, res_got.reverse_left);
                check_field("compare_right", res_want.compare_right, res_got.compare_right);
                check_field("reverse_right", res_want.reverse_right, res_got.reverse_right);
                check_field("speed_left", res_want.speed_left, res_got.speed_left);
                check_field("speed_right", res_want.speed_right, res_got.speed_right);
            end
        end
    end

    // one input transaction, predicted at acceptance
    task automatic send_tick(input logic [15:0] cl, input logic [15:0] cr,
            input logic signed [7:0] tl, input logic signed [7:0] tr);
        tick_t item;
        int    gap;
        item.count_left   = cl;
        item.count_right  = cr;
        item.target_left  = tl;
        item.target_right = tr;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= item;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_tick(item);
        ticks_sent++;
    endtask

    // one register write transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_COEFF_NOW:   cfg_shadow.coeff_now       = data[15:0];
            REG_COEFF_LAST:  cfg_shadow.coeff_last      = data[15:0];
            REG_COEFF_OLDER: cfg_shadow.coeff_older     = data[15:0];
            REG_SPEED_GAIN:  cfg_shadow.speed_gain      = data;
            REG_WRAP_THR:    cfg_shadow.wrap_threshold  = data[15:0];
            REG_ENC_TOP:     cfg_shadow.encoder_top     = data[15:0];
            REG_PWM_TOP:     cfg_shadow.pwm_top         = data[15:0];
            REG_DUTY_FULL:   cfg_shadow.duty_full_scale = data[15:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // 16 bit registers get junk in the unused upper data bits
    task automatic write16(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        write_reg(idx, {4'($urandom), v});
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // defaults after reset: zero set point, full set points, wrap both ways,
    // delta right at the threshold and one past it, control clamp
    task automatic test_reset_defaults();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        settings_used++;
        send_tick(16'd0, 16'd0, 8'sd0, 8'sd0);
        send_tick(16'd150, 16'd65386, 8'sd100, 8'sd100);
        send_tick(16'd65500, 16'd200, -8'sd100, -8'sd100);
        send_tick(16'd164, 16'd401, 8'sd1, -8'sd1);
        send_tick(16'd364, 16'd601, -8'sd1, 8'sd1);
        send_tick(16'd364, 16'd802, 8'sd0, 8'sd50);
        repeat (3) send_tick(16'd364, 16'd802, 8'sd100, -8'sd100);
        send_tick(16'd364, 16'd802, -8'sd100, 8'sd100);
    endtask

    // tiny pwm period with full duty scale, reversed compare floors at zero
    task automatic test_reverse_floor();
        drain();
        write16(REG_PWM_TOP, 16'd1);
        write16(REG_DUTY_FULL, 16'd65535);
        settings_used++;
        repeat (2) send_tick(16'd364, 16'd802, -8'sd100, 8'sd100);
        send_tick(16'd364, 16'd802, 8'sd100, -8'sd100);
    endtask

    // huge gain and no wrap, speed and error saturate, extreme coefficients
    task automatic test_speed_saturation();
        drain();
        write_reg(REG_SPEED_GAIN, 20'hFFFFF);
        write16(REG_WRAP_THR, 16'd65535);
        write16(REG_ENC_TOP, 16'd65535);
        write16(REG_COEFF_NOW, 16'h7FFF);
        write16(REG_COEFF_LAST, 16'h8000);
        write16(REG_COEFF_OLDER, 16'h7FFF);
        write16(REG_PWM_TOP, 16'd65535);
        settings_used++;
        send_tick(16'd65535, 16'd0, 8'sd100, -8'sd100);
        send_tick(16'd0, 16'd65535, -8'sd100, 8'sd100);
        send_tick(16'd65535, 16'd0, 8'sd100, -8'sd100);
    endtask

    // zero threshold and zero encoder top, every nonzero delta gets a wrap fix
    task automatic test_wrap_edges();
        drain();
        write16(REG_WRAP_THR, 16'd0);
        write16(REG_ENC_TOP, 16'd0);
        write_reg(REG_SPEED_GAIN, 20'd0);
        write16(REG_COEFF_OLDER, 16'h8000);
        write16(REG_DUTY_FULL, 16'd1);
        settings_used++;
        send_tick(16'd5, 16'd65530, 8'sd60, -8'sd60);
        drain();
        write_reg(REG_SPEED_GAIN, 20'd30000);
        settings_used++;
        send_tick(16'd4, 16'd65531, -8'sd30, 8'sd30);
        send_tick(16'd4, 16'd65531, 8'sd127 - 8'sd27, 8'sd0);
    endtask

    // writes to indexes past the last register are ignored
    task automatic test_unused_index();
        drain();
        write_reg(CFG_IDX_W'(REG_DUTY_FULL + 1 + $urandom_range(0, 3)), 20'($urandom));
        write_reg(CFG_IDX_W'(REG_DUTY_FULL + 4 + $urandom_range(0, 4)), 20'($urandom));
        send_tick(16'd9, 16'd65520, 8'sd20, 8'sd20);
        send_tick(16'd9, 16'd65520, 8'sd20, 8'sd20);
    endtask

    // full register set for one random phase
    task automatic apply_settings(input cfg_style_t style);
        int cn, cl, co, gn, th, tp, pt, df;
        case (style)
            CFG_DEFAULT: begin
                cn = 5407; cl = -1843; co = 0; gn = 49276;
                th = 200;  tp = 65535; pt = 999; df = 999;
            end
            CFG_MILD: begin
                cn = $urandom_range(2000, 8000);
                cl = -int'($urandom_range(0, 4000));
                co = int'($urandom_range(0, 2000)) - 1000;
                gn = $urandom_range(10000, 100000);
                th = $urandom_range(100, 1000);
                tp = 65535;
                pt = $urandom_range(500, 2000);
                df = $urandom_range(500, 2000);
            end
            CFG_SHORT_ENCODER: begin
                cn = $urandom_range(2000, 8000);
                cl = -int'($urandom_range(0, 3000));
                co = int'($urandom_range(0, 1000)) - 500;
                gn = $urandom_range(20000, 80000);
                tp = $urandom_range(99, 4095);
                th = tp / 2;
                pt = $urandom_range(1, 65535);
                df = $urandom_range(1, 65535);
            end
            CFG_EXTREME: begin
                cn = pick_edge(-32768, 32767);
                cl = pick_edge(-32768, 32767);
                co = pick_edge(-32768, 32767);
                gn = pick_edge(0, 1048575);
                th = pick_edge(0, 65535);
                tp = pick_edge(0, 65535);
                pt = pick_edge(1, 65535);
                df = pick_edge(1, 65535);
            end
            default: begin
                cn = $urandom; cl = $urandom; co = $urandom;
                gn = $urandom_range(0, 1048575);
                th = $urandom_range(0, 65535);
                tp = $urandom_range(0, 65535);
                pt = $urandom_range(1, 65535);
                df = $urandom_range(1, 65535);
            end
        endcase
        write16(REG_COEFF_NOW, cn[15:0]);
        write16(REG_COEFF_LAST, cl[15:0]);
        write16(REG_COEFF_OLDER, co[15:0]);
        write_reg(REG_SPEED_GAIN, gn[19:0]);
        write16(REG_WRAP_THR, th[15:0]);
        write16(REG_ENC_TOP, tp[15:0]);
        write16(REG_PWM_TOP, pt[15:0]);
        write16(REG_DUTY_FULL, df[15:0]);
        settings_used++;
    endtask

    // mostly steady wheel motion with held set points, some raw noise ticks
    task automatic run_motion(input int n);
        int m, vmax, thr, r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) begin
                for (int w = 0; w < 2; w++) begin
                    if (run_w[w] == 0) begin
                        run_w[w] = $urandom_range(3, 25);
                        thr  = cfg_shadow.wrap_threshold;
                        vmax = (thr > 0 && thr < 2000) ? thr : 2000;
                        vel_w[w] = int'($urandom_range(0, 2 * vmax)) - vmax;
                        r = $urandom_range(9);
                        if (r == 0)
                            tgt_w[w] = 8'sd0;
                        else if (r == 1)
                            tgt_w[w] = 8'sd100;
                        else if (r == 2)
                            tgt_w[w] = -8'sd100;
                        else
                            tgt_w[w] = rand_pct();
                    end
                    run_w[w]--;
                    m = int'(cfg_shadow.encoder_top) + 1;
                    pos_w[w] = (pos_w[w] + vel_w[w] + int'($urandom_range(0, 6)) - 3) % m;
                    if (pos_w[w] < 0)
                        pos_w[w] = pos_w[w] + m;
                end
                send_tick(pos_w[0][15:0], pos_w[1][15:0], tgt_w[0], tgt_w[1]);
            end else begin
                send_tick(16'($urandom), 16'($urandom), rand_pct(), rand_pct());
            end
        end
    endtask

    // five register settings, the first with no idling on either side
    task automatic test_random_phases();
        cfg_style_t style;
        for (int p = 0; p < 5; p++) begin
            drain();
            style = cfg_style_t'(p);
            apply_settings(style);
            gaps_on   = (p != 0);
            stalls_on = (p != 0) && (p != 3);
            run_motion(90);
        end
    endtask

    // main sequence
    initial begin
        restore_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_reverse_floor();
        test_speed_saturation();
        test_wrap_edges();
        test_unused_index();
        test_random_phases();
        drain();
        $display("covered %0d control ticks and %0d checked results", ticks_sent, results_seen);
        $display("with %0d register writes over %0d register settings", reg_writes,
                 settings_used);
        if (fail_count == 0) begin
            $display("PASS dual_wheel_incremental_pid_speed_unit");
        end else begin
            $display("FAIL dual_wheel_incremental_pid_speed_unit");
        end
        $finish;
    end

endmodule
